### rtl/i2cms_pkg.sv
// i2cms_pkg: shared types and constants for the i2c master bit sequencer
// used by i2cms_core and i2c_master_bit_sequencer_unit, no dependencies

package i2cms_pkg;

  localparam int MAX_LEN = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_BEGIN = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NACK     = 2'd1,
    ST_ZERO_LEN = 2'd2,
    ST_BUSY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TX    = 3'd3,
    PH_RX    = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  // input word, lowest field in the lowest bits
  typedef struct packed {
    logic       send_stop;
    logic [4:0] transfer_length;
    logic       read_not_write;
    logic [6:0] target_address;
    logic [3:0] load_index;
    logic [7:0] load_value;
    logic       sda_level;
    logic       scl_level;
  } in_word_t;

  // result word, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0] bytes_done;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       rx_valid;
    status_t    status;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl_drive;
  } res_word_t;

endpackage

### rtl/i2cms_core.sv
// i2cms_core: sequencer state, transmit buffer and one-step bus logic
// depends on i2cms_pkg

module i2cms_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  i2cms_pkg::cmd_t     cmd,
  input  i2cms_pkg::in_word_t din,
  output i2cms_pkg::res_word_t res
);

  localparam int MAX_LEN_DEPTH = i2cms_pkg::MAX_LEN;

  i2cms_pkg::phase_t phase, phase_next;
  logic [4:0] bit_step, bit_step_next;
  logic [1:0] edge_step, edge_step_next;
  logic       stretch_seen, stretch_seen_next;
  logic [4:0] byte_counter, byte_counter_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [6:0] latched_address, latched_address_next;
  logic       latched_read, latched_read_next;
  logic [4:0] latched_length, latched_length_next;
  logic       latched_stop, latched_stop_next;
  logic       nack_flag, nack_flag_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;

  logic [7:0] tx_buf [MAX_LEN_DEPTH];

  always_comb begin
    logic                done;
    logic                got;
    logic                hold;
    logic                last;
    logic                finish;
    logic [4:0]          bc_inc;
    logic [7:0]          sb;
    i2cms_pkg::status_t  status;

    phase_next           = phase;
    bit_step_next        = bit_step;
    edge_step_next       = edge_step;
    stretch_seen_next    = stretch_seen;
    byte_counter_next    = byte_counter;
    shift_byte_next      = shift_byte;
    latched_address_next = latched_address;
    latched_read_next    = latched_read;
    latched_length_next  = latched_length;
    latched_stop_next    = latched_stop;
    nack_flag_next       = nack_flag;
    scl_drive_next       = scl_drive;
    sda_drive_next       = sda_drive;
    done   = 1'b0;
    got    = 1'b0;
    finish = 1'b0;
    status = i2cms_pkg::ST_OK;
    hold   = ~din.scl_level | stretch_seen;
    last   = (byte_counter + 5'd1) >= latched_length;
    bc_inc = byte_counter + 5'd1;
    sb     = shift_byte;

    case (cmd)
      i2cms_pkg::CMD_BEGIN: begin
        if (phase != i2cms_pkg::PH_IDLE) begin
          status = i2cms_pkg::ST_BUSY;
        end else if (din.transfer_length == 5'd0) begin
          status = i2cms_pkg::ST_ZERO_LEN;
        end else begin
          latched_address_next = din.target_address;
          latched_read_next    = din.read_not_write;
          latched_length_next  = (din.transfer_length > 5'(i2cms_pkg::MAX_LEN)) ?
                                 5'(i2cms_pkg::MAX_LEN) : din.transfer_length;
          latched_stop_next    = din.send_stop;
          byte_counter_next    = 5'd0;
          nack_flag_next       = 1'b0;
          stretch_seen_next    = 1'b0;
          edge_step_next       = 2'd0;
          bit_step_next        = 5'd0;
          phase_next           = i2cms_pkg::PH_START;
        end
      end
      i2cms_pkg::CMD_TICK: begin
        case (phase)
          i2cms_pkg::PH_START: begin
            if (edge_step == 2'd0) begin
              sda_drive_next = 1'b1;
              edge_step_next = 2'd1;
            end else if (edge_step == 2'd1) begin
              scl_drive_next = 1'b1;
              edge_step_next = 2'd2;
            end else begin
              sda_drive_next = 1'b0;
              phase_next     = i2cms_pkg::PH_ADDR;
              bit_step_next  = 5'd0;
            end
          end
          i2cms_pkg::PH_ADDR, i2cms_pkg::PH_TX: begin
            if (bit_step == 5'd0) begin
              sb = (phase == i2cms_pkg::PH_ADDR) ? {latched_address, latched_read}
                                                : tx_buf[byte_counter[i2cms_pkg::IDX_W-1:0]];
              shift_byte_next = sb;
            end
            if (bit_step < 5'd16) begin
              if (!bit_step[0]) begin
                scl_drive_next = 1'b0;
                sda_drive_next = sb[3'd7 - bit_step[3:1]];
              end else begin
                scl_drive_next = 1'b1;
              end
              bit_step_next = bit_step + 5'd1;
            end else if (bit_step == 5'd16) begin
              scl_drive_next = 1'b0;
              sda_drive_next = 1'b1;
              bit_step_next  = bit_step + 5'd1;
            end else if (bit_step == 5'd17) begin
              scl_drive_next = 1'b1;
              bit_step_next  = bit_step + 5'd1;
            end else begin
              stretch_seen_next = ~din.scl_level;
              if (!hold) begin
                scl_drive_next = 1'b0;
                if (din.sda_level) begin
                  nack_flag_next = 1'b1;
                  phase_next     = i2cms_pkg::PH_STOP;
                  edge_step_next = 2'd0;
                end else if (phase == i2cms_pkg::PH_ADDR) begin
                  phase_next    = latched_read ? i2cms_pkg::PH_RX : i2cms_pkg::PH_TX;
                  bit_step_next = 5'd0;
                end else begin
                  finish = 1'b1;
                end
              end
            end
          end
          i2cms_pkg::PH_RX: begin
            if (bit_step < 5'd16) begin
              if (!bit_step[0]) begin
                if (bit_step == 5'd0) begin
                  sda_drive_next  = 1'b1;
                  shift_byte_next = 8'd0;
                end
                scl_drive_next = 1'b1;
                bit_step_next  = bit_step + 5'd1;
              end else begin
                stretch_seen_next = ~din.scl_level;
                if (!hold) begin
                  shift_byte_next = {shift_byte[6:0], din.sda_level};
                  scl_drive_next  = 1'b0;
                  if (bit_step == 5'd15) begin
                    got = 1'b1;
                    if (!last) begin
                      sda_drive_next = 1'b0;
                    end
                  end
                  bit_step_next = bit_step + 5'd1;
                end
              end
            end else if (bit_step == 5'd16) begin
              scl_drive_next = 1'b1;
              bit_step_next  = bit_step + 5'd1;
            end else begin
              stretch_seen_next = ~din.scl_level;
              if (!hold) begin
                scl_drive_next = 1'b0;
                sda_drive_next = 1'b1;
                finish         = 1'b1;
              end
            end
          end
          i2cms_pkg::PH_STOP: begin
            if (edge_step == 2'd0) begin
              sda_drive_next = 1'b0;
              edge_step_next = 2'd1;
            end else if (edge_step == 2'd1) begin
              scl_drive_next = 1'b1;
              edge_step_next = 2'd2;
            end else begin
              sda_drive_next = 1'b1;
              phase_next     = i2cms_pkg::PH_IDLE;
              done           = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // end of a data byte: next byte, stop or finish
        if (finish) begin
          byte_counter_next = bc_inc;
          if (bc_inc < latched_length) begin
            bit_step_next = 5'd0;
          end else if (latched_stop) begin
            phase_next     = i2cms_pkg::PH_STOP;
            edge_step_next = 2'd0;
          end else begin
            phase_next = i2cms_pkg::PH_IDLE;
            done       = 1'b1;
          end
        end
        if (done) begin
          status = nack_flag_next ? i2cms_pkg::ST_NACK : i2cms_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase

    res.scl_drive  = scl_drive_next;
    res.sda_drive  = sda_drive_next;
    res.busy_res   = (phase_next != i2cms_pkg::PH_IDLE);
    res.done_res   = done;
    res.status     = status;
    res.rx_valid   = got;
    res.rx_byte    = got ? shift_byte_next : 8'd0;
    res.rx_index   = got ? byte_counter[3:0] : 4'd0;
    res.bytes_done = byte_counter_next;
  end

  always_ff @(posedge clk) begin
    if (step && cmd == i2cms_pkg::CMD_LOAD) begin
      tx_buf[din.load_index[i2cms_pkg::IDX_W-1:0]] <= din.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cms_pkg::PH_IDLE;
      bit_step        <= 5'd0;
      edge_step       <= 2'd0;
      stretch_seen    <= 1'b0;
      byte_counter    <= 5'd0;
      shift_byte      <= 8'd0;
      latched_address <= 7'd0;
      latched_read    <= 1'b0;
      latched_length  <= 5'd0;
      latched_stop    <= 1'b0;
      nack_flag       <= 1'b0;
      scl_drive       <= 1'b1;
      sda_drive       <= 1'b1;
    end else if (step) begin
      phase           <= phase_next;
      bit_step        <= bit_step_next;
      edge_step       <= edge_step_next;
      stretch_seen    <= stretch_seen_next;
      byte_counter    <= byte_counter_next;
      shift_byte      <= shift_byte_next;
      latched_address <= latched_address_next;
      latched_read    <= latched_read_next;
      latched_length  <= latched_length_next;
      latched_stop    <= latched_stop_next;
      nack_flag       <= nack_flag_next;
      scl_drive       <= scl_drive_next;
      sda_drive       <= sda_drive_next;
    end
  end

endmodule

### rtl/i2c_master_bit_sequencer_unit.sv
// i2c_master_bit_sequencer_unit: top level, stream ports and result skid buffer
// depends on i2cms_pkg and i2cms_core
//
// channel  | dir | handshake          | content
// s_       | in  | s_tvalid/s_tready  | tuser command, tdata pin samples and command fields
// m_       | out | m_tvalid/m_tready  | tdata line drives, status and received byte
//
// one result word per input word, one word per cycle sustained while m_tready stays high
// the step logic sits combinationally between the input port and the result register
// a two-entry output stage (result register plus skid) takes one extra word while the output stalls
// s_tready drops only while both output entries are full
// rst is synchronous, clears the sequencer to idle with both lines released

module i2c_master_bit_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] cmd
  input  logic [1:0]  s_tuser,
  // [0] scl_level, [1] sda_level, [9:2] load_value, [13:10] load_index,
  // [20:14] target_address, [21] read_not_write, [26:22] transfer_length,
  // [27] send_stop, [31:28] zero
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [5:4] status,
  // [6] rx_valid, [14:7] rx_byte, [18:15] rx_index, [23:19] bytes_done
  output logic [23:0] m_tdata
);

  i2cms_pkg::in_word_t  din;
  i2cms_pkg::res_word_t res;
  i2cms_pkg::res_word_t out_word;
  i2cms_pkg::res_word_t skid_word;
  logic                 out_valid;
  logic                 skid_valid;
  logic                 take;
  logic                 pop;

  assign din      = i2cms_pkg::in_word_t'(s_tdata[$bits(i2cms_pkg::in_word_t)-1:0]);
  assign s_tready = ~skid_valid;
  assign take     = s_tvalid & s_tready;
  assign pop      = out_valid & m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;

  i2cms_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .cmd  (i2cms_pkg::cmd_t'(s_tuser)),
    .din  (din),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else if (take) begin
        out_word <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (take) begin
      if (!out_valid) begin
        out_word  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= res;
        skid_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.done_res && out_word.busy_res))
    else $error("transfer reported done while still busy");

  a_rx_while_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.rx_valid) |-> out_word.busy_res)
    else $error("received byte reported outside a transfer");

  a_nack_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status == i2cms_pkg::ST_NACK) |-> out_word.done_res)
    else $error("nack status without a finished transfer");
`endif

endmodule

### sim/i2c_master_bit_sequencer_unit_tb.sv
// i2c_master_bit_sequencer_unit_tb: stream-level testbench for the i2c master bit sequencer
// plays the slave side pin by pin and checks every result word against an in-bench predictor
// depends on i2cms_pkg and i2c_master_bit_sequencer_unit

module i2c_master_bit_sequencer_unit_tb;
  import i2cms_pkg::*;

  localparam int ITEMS = 1650;

  typedef enum logic [1:0] {
    XFER_WAIT,
    XFER_ACK,
    XFER_NACK
  } ack_t;

  typedef struct packed {
    cmd_t      c;
    in_word_t  w;
  } cmd_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  i2c_master_bit_sequencer_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // predicted sequencer state
  phase_t     ph = PH_IDLE;
  logic [4:0] bit_no = '0;
  logic [1:0] edge_no = '0;
  logic       held = 1'b0;
  logic [4:0] byte_cnt = '0;
  logic [7:0] shreg = '0;
  logic [6:0] addr_l = '0;
  logic       rd_l = 1'b0;
  logic [4:0] len_l = '0;
  logic       stop_l = 1'b0;
  logic       nack_l = 1'b0;
  logic       scl_o = 1'b1;
  logic       sda_o = 1'b1;
  logic [7:0] tx_mem [MAX_LEN];
  logic [MAX_LEN-1:0] loaded_mask = '0;

  cmd_word_t  cmd_words_q [$];
  res_word_t  bus_results_q [$];

  int busy_words = 0;
  int stretch_pct = 0;
  int addr_nack_pct = 0;
  int data_nack_pct = 0;
  int n_done = 0, n_nacked = 0, n_rx = 0, n_rejected = 0;
  int mismatches = 0;
  int checked = 0;
  int cycle_count = 0;
  int cycle_limit = 1000000;
  int idle_gap = 0;
  int ready_hold = 0;
  bit long_hold_done = 1'b0;
  cmd_word_t cur;
  res_word_t seen, want;

  function automatic logic hold_clock(logic scl);
    if (!scl) begin
      held = 1'b1;
      return 1'b1;
    end
    if (held) begin
      held = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one step of shifting out shreg and sampling the ack
  function automatic ack_t send_bit(logic scl, logic sda);
    if (bit_no < 5'd16) begin
      if (!bit_no[0]) begin
        scl_o = 1'b0;
        sda_o = shreg[3'd7 - bit_no[3:1]];
      end else begin
        scl_o = 1'b1;
      end
      bit_no++;
      return XFER_WAIT;
    end
    if (bit_no == 5'd16) begin
      scl_o = 1'b0;
      sda_o = 1'b1;
      bit_no++;
      return XFER_WAIT;
    end
    if (bit_no == 5'd17) begin
      scl_o = 1'b1;
      bit_no++;
      return XFER_WAIT;
    end
    if (hold_clock(scl)) return XFER_WAIT;
    scl_o = 1'b0;
    return sda ? XFER_NACK : XFER_ACK;
  endfunction

  function automatic logic next_byte();
    byte_cnt++;
    if (byte_cnt < len_l) begin
      bit_no = '0;
      return 1'b0;
    end
    if (stop_l) begin
      ph = PH_STOP;
      edge_no = '0;
      return 1'b0;
    end
    ph = PH_IDLE;
    return 1'b1;
  endfunction

  task automatic sequence_step(input cmd_t c, input in_word_t w, output res_word_t r);
    status_t st;
    logic    fin;
    logic    got;
    logic    last;
    ack_t    a;
    st = ST_OK;
    fin = 1'b0;
    got = 1'b0;
    case (c)
      CMD_LOAD: begin
        if (w.load_index < MAX_LEN) tx_mem[w.load_index] = w.load_value;
      end
      CMD_BEGIN: begin
        if (ph != PH_IDLE) st = ST_BUSY;
        else if (w.transfer_length == 5'd0) st = ST_ZERO_LEN;
        else begin
          addr_l = w.target_address;
          rd_l = w.read_not_write;
          len_l = (w.transfer_length > MAX_LEN) ? 5'(MAX_LEN) : w.transfer_length;
          stop_l = w.send_stop;
          byte_cnt = '0;
          nack_l = 1'b0;
          held = 1'b0;
          edge_no = '0;
          bit_no = '0;
          ph = PH_START;
        end
      end
      CMD_TICK: begin
        case (ph)
          PH_START: begin
            if (edge_no == 2'd0) begin
              sda_o = 1'b1;
              edge_no = 2'd1;
            end else if (edge_no == 2'd1) begin
              scl_o = 1'b1;
              edge_no = 2'd2;
            end else begin
              sda_o = 1'b0;
              ph = PH_ADDR;
              bit_no = '0;
            end
          end
          PH_ADDR: begin
            if (bit_no == 5'd0) shreg = {addr_l, rd_l};
            a = send_bit(w.scl_level, w.sda_level);
            if (a == XFER_NACK) begin
              nack_l = 1'b1;
              ph = PH_STOP;
              edge_no = '0;
            end else if (a == XFER_ACK) begin
              ph = rd_l ? PH_RX : PH_TX;
              bit_no = '0;
            end
          end
          PH_TX: begin
            if (bit_no == 5'd0) shreg = tx_mem[byte_cnt[3:0]];
            a = send_bit(w.scl_level, w.sda_level);
            if (a == XFER_NACK) begin
              nack_l = 1'b1;
              ph = PH_STOP;
              edge_no = '0;
            end else if (a == XFER_ACK) begin
              fin = next_byte();
            end
          end
          PH_RX: begin
            last = (byte_cnt + 5'd1 >= len_l);
            if (bit_no < 5'd16) begin
              if (!bit_no[0]) begin
                if (bit_no == 5'd0) begin
                  sda_o = 1'b1;
                  shreg = '0;
                end
                scl_o = 1'b1;
                bit_no++;
              end else if (!hold_clock(w.scl_level)) begin
                shreg = {shreg[6:0], w.sda_level};
                scl_o = 1'b0;
                if (bit_no == 5'd15) begin
                  got = 1'b1;
                  if (!last) sda_o = 1'b0;
                end
                bit_no++;
              end
            end else if (bit_no == 5'd16) begin
              scl_o = 1'b1;
              bit_no++;
            end else if (!hold_clock(w.scl_level)) begin
              scl_o = 1'b0;
              sda_o = 1'b1;
              fin = next_byte();
            end
          end
          PH_STOP: begin
            if (edge_no == 2'd0) begin
              sda_o = 1'b0;
              edge_no = 2'd1;
            end else if (edge_no == 2'd1) begin
              scl_o = 1'b1;
              edge_no = 2'd2;
            end else begin
              sda_o = 1'b1;
              ph = PH_IDLE;
              fin = 1'b1;
            end
          end
          default: ;
        endcase
        if (fin) st = nack_l ? ST_NACK : ST_OK;
      end
      default: ;
    endcase
    r.scl_drive = scl_o;
    r.sda_drive = sda_o;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = fin;
    r.status = st;
    r.rx_valid = got;
    r.rx_byte = got ? shreg : 8'd0;
    r.rx_index = got ? byte_cnt[3:0] : 4'd0;
    r.bytes_done = byte_cnt;
  endtask

  function automatic in_word_t rand_word();
    logic [31:0] v;
    v = $urandom;
    return v[27:0];
  endfunction

  task automatic push_word(input cmd_t c, input in_word_t w);
    res_word_t r;
    if (c == CMD_LOAD || c == CMD_BEGIN || (c == CMD_TICK && ph != PH_IDLE)) busy_words++;
    if (c == CMD_LOAD) loaded_mask[w.load_index] = 1'b1;
    sequence_step(c, w, r);
    if (r.done_res) n_done++;
    if (r.done_res && r.status == ST_NACK) n_nacked++;
    if (r.rx_valid) n_rx++;
    if (r.status == ST_ZERO_LEN || r.status == ST_BUSY) n_rejected++;
    cmd_words_q.push_back({c, w});
    bus_results_q.push_back(r);
  endtask

  // slave side: ack, stretch and data on the sampling steps, rare garbage pins
  task automatic slave_tick();
    in_word_t w;
    logic     scl;
    logic     sda;
    scl = 1'($urandom_range(0, 1));
    sda = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) >= 3) begin
      if ((ph == PH_ADDR || ph == PH_TX) && bit_no >= 5'd18) begin
        scl = $urandom_range(0, 99) >= stretch_pct;
        sda = $urandom_range(0, 99) < ((ph == PH_ADDR) ? addr_nack_pct : data_nack_pct);
      end else if (ph == PH_RX && (bit_no >= 5'd17 || bit_no[0])) begin
        scl = $urandom_range(0, 99) >= stretch_pct;
      end
    end
    w = rand_word();
    w.scl_level = scl;
    w.sda_level = sda;
    push_word(CMD_TICK, w);
  endtask

  task automatic start_transfer(input logic [6:0] addr, input logic rd, input logic [4:0] len,
                                input logic stop);
    in_word_t w;
    int       i;
    if (!rd) begin
      for (i = 0; i < len && i < MAX_LEN; i++) begin
        if (!loaded_mask[i]) begin
          w = rand_word();
          w.load_index = 4'(i);
          push_word(CMD_LOAD, w);
        end
      end
    end
    w = rand_word();
    w.target_address = addr;
    w.read_not_write = rd;
    w.transfer_length = len;
    w.send_stop = stop;
    push_word(CMD_BEGIN, w);
  endtask

  task automatic drive_until_idle(input int mix);
    in_word_t w;
    while (ph != PH_IDLE) begin
      if ($urandom_range(0, 99) < mix) begin
        w = rand_word();
        case ($urandom_range(0, 2))
          0: push_word(CMD_LOAD, w);
          1: push_word(CMD_BEGIN, w);
          default: push_word(CMD_NOP, w);
        endcase
      end else begin
        slave_tick();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    mismatches++;
    if (mismatches <= 40)
      $display("word %0d: %s expected %0h got %0h", checked, what, exp_val, got_val);
  endtask

  initial begin
    in_word_t    w;
    logic [4:0]  len;
    int          r;
    w = rand_word();
    w.load_index = 4'd0;
    w.load_value = 8'h00;
    push_word(CMD_LOAD, w);
    w.load_index = 4'd15;
    w.load_value = 8'hFF;
    push_word(CMD_LOAD, w);
    w = rand_word();
    w.scl_level = 1'b0;
    w.sda_level = 1'b0;
    push_word(CMD_TICK, w);
    push_word(CMD_NOP, rand_word());
    start_transfer(7'h7F, 1'b0, 5'd0, 1'b1);
    start_transfer(7'h7F, 1'b0, 5'd1, 1'b1);
    push_word(CMD_BEGIN, rand_word());
    drive_until_idle(0);
    stretch_pct = 30;
    start_transfer(7'h00, 1'b1, 5'd2, 1'b0);
    drive_until_idle(0);
    start_transfer(7'h55, 1'b1, 5'd1, 1'b1);
    drive_until_idle(0);
    stretch_pct = 10;
    start_transfer(7'h2A, 1'b0, 5'd31, 1'b0);
    drive_until_idle(0);
    start_transfer(7'h13, 1'b1, 5'd16, 1'b1);
    drive_until_idle(0);
    addr_nack_pct = 100;
    start_transfer(7'h6C, 1'b0, 5'd2, 1'b1);
    drive_until_idle(0);
    addr_nack_pct = 0;
    data_nack_pct = 100;
    start_transfer(7'h31, 1'b0, 5'd3, 1'b0);
    drive_until_idle(0);

    while (busy_words < ITEMS) begin
      repeat ($urandom_range(0, 2)) begin
        w = rand_word();
        case ($urandom_range(0, 2))
          0: push_word(CMD_TICK, w);
          1: push_word(CMD_LOAD, w);
          default: push_word(CMD_NOP, w);
        endcase
      end
      case ($urandom_range(0, 2))
        0: stretch_pct = 0;
        1: stretch_pct = 10;
        default: stretch_pct = 25;
      endcase
      addr_nack_pct = 5;
      data_nack_pct = 4;
      r = $urandom_range(0, 99);
      if (r < 3) len = 5'd0;
      else if (r < 6) len = 5'($urandom_range(17, 31));
      else if (r < 16) len = 5'($urandom_range(4, 16));
      else len = 5'($urandom_range(1, 3));
      start_transfer(7'($urandom), 1'($urandom_range(0, 1)), len,
                     1'($urandom_range(0, 1)));
      drive_until_idle(4);
    end

    cycle_limit = cmd_words_q.size() * 40 + 5000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("checked %0d result words over %0d active words", checked, busy_words);
    $display("%0d transfers finished, %0d of them nacked, %0d bytes read, %0d begins refused",
             n_done, n_nacked, n_rx, n_rejected);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // command word driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (idle_gap > 0) begin
        idle_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_words_q.size() > 0) begin
        cur = cmd_words_q.pop_front();
        s_tuser <= cur.c;
        s_tdata <= {4'b0, cur.w};
        s_tvalid <= 1'b1;
        if (cmd_words_q.size() >= 200 && $urandom_range(0, 9) == 0)
          idle_gap = $urandom_range(1, 4);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata;
      if (bus_results_q.size() == 0) begin
        report_mismatch("unexpected word", 0, int'(m_tdata));
      end else begin
        want = bus_results_q.pop_front();
        if (seen.scl_drive !== want.scl_drive)
          report_mismatch("scl_drive", int'(want.scl_drive), int'(seen.scl_drive));
        if (seen.sda_drive !== want.sda_drive)
          report_mismatch("sda_drive", int'(want.sda_drive), int'(seen.sda_drive));
        if (seen.busy_res !== want.busy_res)
          report_mismatch("busy_res", int'(want.busy_res), int'(seen.busy_res));
        if (seen.done_res !== want.done_res)
          report_mismatch("done_res", int'(want.done_res), int'(seen.done_res));
        if (seen.status !== want.status)
          report_mismatch("status", int'(want.status), int'(seen.status));
        if (seen.rx_valid !== want.rx_valid)
          report_mismatch("rx_valid", int'(want.rx_valid), int'(seen.rx_valid));
        if (seen.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", int'(want.rx_byte), int'(seen.rx_byte));
        if (seen.rx_index !== want.rx_index)
          report_mismatch("rx_index", int'(want.rx_index), int'(seen.rx_index));
        if (seen.bytes_done !== want.bytes_done)
          report_mismatch("bytes_done", int'(want.bytes_done), int'(seen.bytes_done));
      end
      checked++;
    end
  end

  // ready control, one long hold to back up the output stage and stall the input
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else if (!long_hold_done && checked >= 300) begin
      long_hold_done = 1'b1;
      ready_hold = 63;
      m_tready <= 1'b0;
    end else if (cmd_words_q.size() >= 200 && $urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               bus_results_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
